[rtl/lcdns_pkg.sv]
package lcdns_pkg;

    // request codes carried on s_tuser
    localparam logic [2:0] OP_DATA    = 3'd0;
    localparam logic [2:0] OP_COMMAND = 3'd1;
    localparam logic [2:0] OP_CLEAR   = 3'd2;
    localparam logic [2:0] OP_HOME    = 3'd3;
    localparam logic [2:0] OP_CURSOR  = 3'd4;
    localparam logic [2:0] OP_CONTROL = 3'd5;
    localparam logic [2:0] OP_CGRAM   = 3'd6;
    localparam logic [2:0] OP_INIT    = 3'd7;

    // configuration register indexes
    localparam logic CFG_DATA_WAIT    = 1'b0;
    localparam logic CFG_COMMAND_WAIT = 1'b1;

    localparam logic [15:0] DATA_WAIT_RESET    = 16'd200;
    localparam logic [15:0] COMMAND_WAIT_RESET = 16'd5000;

    // job kinds handed from front end to back end
    localparam logic [1:0] JOB_BYTE  = 2'd0;
    localparam logic [1:0] JOB_ERROR = 2'd1;
    localparam logic [1:0] JOB_INIT  = 2'd2;

    localparam logic [7:0] CMD_CLEAR    = 8'h01;
    localparam logic [7:0] CMD_HOME     = 8'h02;
    localparam logic [7:0] CMD_DDRAM    = 8'h80;
    localparam logic [7:0] ROW2_OFFSET  = 8'h40;

    localparam int QUEUE_DEPTH = 2;

    localparam int          STEP_W    = 5;
    localparam logic [4:0]  INIT_LAST = 5'd16;

    typedef struct packed {
        logic [1:0] kind;
        logic       rs;
        logic [7:0] data;
    } job_t;

    typedef struct packed {
        logic [3:0]  nibble;
        logic        strobe;
        logic [15:0] wait_us;
        logic        use_cfg;
    } init_step_t;

    // command bytes of the init request, after the wake-up nibbles
    function automatic logic [7:0] init_byte(input logic [2:0] idx);
        logic [7:0] b;
        unique case (idx)
            3'd0:    b = 8'h28;
            3'd1:    b = 8'h08;
            3'd2:    b = 8'h01;
            3'd3:    b = 8'h06;
            3'd4:    b = 8'h0C;
            default: b = 8'h01;
        endcase
        return b;
    endfunction

    function automatic init_step_t init_step(input logic [4:0] step);
        init_step_t s;
        logic [4:0] idx;
        logic [7:0] b;
        idx = step - 5'd5;
        b   = init_byte(idx[3:1]);
        unique case (step)
            5'd0:    s = '{nibble: 4'h0, strobe: 1'b0, wait_us: 16'd15000, use_cfg: 1'b0};
            5'd1:    s = '{nibble: 4'h3, strobe: 1'b1, wait_us: 16'd5000,  use_cfg: 1'b0};
            5'd2:    s = '{nibble: 4'h3, strobe: 1'b1, wait_us: 16'd200,   use_cfg: 1'b0};
            5'd3:    s = '{nibble: 4'h3, strobe: 1'b1, wait_us: 16'd200,   use_cfg: 1'b0};
            5'd4:    s = '{nibble: 4'h2, strobe: 1'b1, wait_us: 16'd5000,  use_cfg: 1'b0};
            default: s = '{nibble: (idx[0] ? b[3:0] : b[7:4]), strobe: 1'b1,
                           wait_us: 16'd0, use_cfg: 1'b1};
        endcase
        return s;
    endfunction

endpackage

[rtl/lcdns_front.sv]
module lcdns_front (
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [2:0]          s_tuser,   // op
    input  logic [31:0]         s_tdata,   // data_byte, row, column, display_on,
                                           // cursor_on, blink_on, cgram_offset
    input  logic                q_full,
    output logic                q_push,
    output lcdns_pkg::job_t     q_job
);

    logic [7:0] data_byte;
    logic [1:0] row;
    logic [7:0] column;
    logic [1:0] display_on;
    logic [1:0] cursor_on;
    logic [1:0] blink_on;
    logic [3:0] cgram_offset;
    logic [7:0] col_m1;

    assign data_byte    = s_tdata[7:0];
    assign row          = s_tdata[9:8];
    assign column       = s_tdata[17:10];
    assign display_on   = s_tdata[19:18];
    assign cursor_on    = s_tdata[21:20];
    assign blink_on     = s_tdata[23:22];
    assign cgram_offset = s_tdata[27:24];

    assign col_m1 = column - 8'd1;

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    always_comb begin
        q_job.kind = lcdns_pkg::JOB_BYTE;
        q_job.rs   = 1'b0;
        q_job.data = 8'h00;
        unique case (s_tuser)
            lcdns_pkg::OP_DATA: begin
                q_job.rs   = 1'b1;
                q_job.data = data_byte;
            end
            lcdns_pkg::OP_COMMAND: begin
                q_job.data = data_byte;
            end
            lcdns_pkg::OP_CLEAR: begin
                q_job.data = lcdns_pkg::CMD_CLEAR;
            end
            lcdns_pkg::OP_HOME: begin
                q_job.data = lcdns_pkg::CMD_HOME;
            end
            lcdns_pkg::OP_CURSOR: begin
                // rows other than one and two ignore the column
                priority if (row == 2'd1) begin
                    q_job.data = lcdns_pkg::CMD_DDRAM + col_m1;
                end else if (row == 2'd2) begin
                    q_job.data = lcdns_pkg::CMD_DDRAM + lcdns_pkg::ROW2_OFFSET + col_m1;
                end else begin
                    q_job.data = lcdns_pkg::CMD_DDRAM;
                end
            end
            lcdns_pkg::OP_CONTROL: begin
                if (display_on[1] || cursor_on[1] || blink_on[1]) begin
                    q_job.kind = lcdns_pkg::JOB_ERROR;
                end else begin
                    q_job.data = {4'b0000, 1'b1, display_on[0], cursor_on[0], blink_on[0]};
                end
            end
            lcdns_pkg::OP_CGRAM: begin
                if (cgram_offset[3]) begin
                    q_job.kind = lcdns_pkg::JOB_ERROR;
                end else begin
                    q_job.data = {5'b01000, cgram_offset[2:0]};
                end
            end
            lcdns_pkg::OP_INIT: begin
                q_job.kind = lcdns_pkg::JOB_INIT;
            end
        endcase
    end

endmodule

[rtl/lcdns_queue.sv]
module lcdns_queue #(
    parameter int DEPTH = lcdns_pkg::QUEUE_DEPTH
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  lcdns_pkg::job_t push_job,
    output logic            full,
    input  logic            pop,
    output lcdns_pkg::job_t pop_job,
    output logic            empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    lcdns_pkg::job_t   mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_next;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign pop_job = mem[rd_ptr_reg];

    assign wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_next;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_next;
            end
            unique case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        full |-> !push)
        else $error("request queue written while full");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        empty |-> !pop)
        else $error("request queue read while empty");

endmodule

[rtl/lcdns_back.sv]
module lcdns_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic [15:0]     data_wait_us,
    input  logic [15:0]     command_wait_us,
    input  lcdns_pkg::job_t job,
    input  logic            job_empty,
    output logic            job_pop,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [23:0]     m_tdata,   // reg_select, nibble, strobe_res, wait_us, error_flag
    output logic            m_tlast
);

    logic [lcdns_pkg::STEP_W-1:0] step_reg;
    logic                         m_tvalid_reg;
    logic                         rs_reg;
    logic [3:0]                   nibble_reg;
    logic                         strobe_reg;
    logic [15:0]                  wait_reg;
    logic                         error_reg;
    logic                         last_reg;

    logic                         advance;
    logic                         rs_c;
    logic [3:0]                   nibble_c;
    logic                         strobe_c;
    logic [15:0]                  wait_c;
    logic                         error_c;
    logic                         last_c;
    lcdns_pkg::init_step_t        init_c;

    // output register frees whenever the current step is taken
    assign advance = !m_tvalid_reg || m_tready;
    assign job_pop = advance && !job_empty && last_c;

    assign init_c = lcdns_pkg::init_step(step_reg);

    always_comb begin
        rs_c     = 1'b0;
        nibble_c = 4'h0;
        strobe_c = 1'b0;
        wait_c   = 16'd0;
        error_c  = 1'b0;
        last_c   = 1'b1;
        unique case (job.kind)
            lcdns_pkg::JOB_BYTE: begin
                rs_c     = job.rs;
                nibble_c = step_reg[0] ? job.data[3:0] : job.data[7:4];
                strobe_c = 1'b1;
                wait_c   = job.rs ? data_wait_us : command_wait_us;
                last_c   = step_reg[0];
            end
            lcdns_pkg::JOB_INIT: begin
                nibble_c = init_c.nibble;
                strobe_c = init_c.strobe;
                wait_c   = init_c.use_cfg ? command_wait_us : init_c.wait_us;
                last_c   = (step_reg == lcdns_pkg::INIT_LAST);
            end
            default: begin
                error_c = 1'b1;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
            step_reg     <= '0;
        end else if (advance) begin
            m_tvalid_reg <= !job_empty;
            if (!job_empty) begin
                step_reg <= last_c ? '0 : step_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && !job_empty) begin
            rs_reg     <= rs_c;
            nibble_reg <= nibble_c;
            strobe_reg <= strobe_c;
            wait_reg   <= wait_c;
            error_reg  <= error_c;
            last_reg   <= last_c;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, error_reg, wait_reg, strobe_reg, nibble_reg, rs_reg};
    assign m_tlast  = last_reg;

    a_step_range: assert property (@(posedge aclk) disable iff (!aresetn)
        step_reg <= lcdns_pkg::INIT_LAST)
        else $error("step counter ran past the init sequence");

    a_pop_marks_last: assert property (@(posedge aclk) disable iff (!aresetn)
        job_pop |=> m_tvalid_reg && last_reg)
        else $error("request retired without a final step");

    a_error_single: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && error_reg) |-> (last_reg && !strobe_reg))
        else $error("error result must be a lone unstrobed step");

endmodule

[rtl/char_lcd_nibble_sequencer.sv]
// channel   ports           tdata fields (low bit up)                    tuser / tlast
// request   s_tvalid/ready  data_byte, row, column, display_on,          op / -
//                           cursor_on, blink_on, cgram_offset
// step      m_tvalid/ready  reg_select, nibble, strobe_res, wait_us,     - / last
//                           error_flag
// config    cfg_we          cfg_index selects register, cfg_wdata value
//
// one step leaves per cycle unless m_tready stalls; a byte request gives 2 steps, an
// error 1, init 17; the back end's step counter and output register set that pace.
// reset (aresetn low at a clock edge) empties the queue, drops m_tvalid and loads
// the wait registers with 200 and 5000 us.
// a stalled m_tready holds the step; requests keep entering until the queue fills.
module char_lcd_nibble_sequencer #(
    parameter int QUEUE_DEPTH = lcdns_pkg::QUEUE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [2:0]  s_tuser,   // op
    input  logic [31:0] s_tdata,   // data_byte, row, column, display_on, cursor_on,
                                   // blink_on, cgram_offset
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // reg_select, nibble, strobe_res, wait_us, error_flag
    output logic        m_tlast
);

    logic [15:0]     data_wait_reg;
    logic [15:0]     command_wait_reg;
    logic            q_full;
    logic            q_empty;
    logic            q_push;
    logic            q_pop;
    lcdns_pkg::job_t push_job;
    lcdns_pkg::job_t pop_job;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            data_wait_reg    <= lcdns_pkg::DATA_WAIT_RESET;
            command_wait_reg <= lcdns_pkg::COMMAND_WAIT_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                lcdns_pkg::CFG_DATA_WAIT:    data_wait_reg    <= cfg_wdata;
                lcdns_pkg::CFG_COMMAND_WAIT: command_wait_reg <= cfg_wdata;
            endcase
        end
    end

    lcdns_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_job    (push_job)
    );

    lcdns_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (q_pop),
        .pop_job  (pop_job),
        .empty    (q_empty)
    );

    lcdns_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .data_wait_us    (data_wait_reg),
        .command_wait_us (command_wait_reg),
        .job             (pop_job),
        .job_empty       (q_empty),
        .job_pop         (q_pop),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tlast         (m_tlast)
    );

endmodule
